### sv/ggl_pkg.sv
// Shared constants, types and controller/datapath interface for the gradient and Laplacian core.
`default_nettype none

package ggl_pkg;

	localparam int AXIS_BITS   = 5;
	localparam int VALUE_WIDTH = 32;
	localparam int DIM_W       = AXIS_BITS + 1;
	localparam int ADDR_W      = 3 * AXIS_BITS;
	localparam int DEPTH       = 1 << ADDR_W;
	localparam int SPACING_W   = 32;
	localparam int FRAC_BITS   = 16;
	localparam int CFG_IDX_W   = 3;

	// neighbour difference, and forward minus backward difference
	localparam int DIFF_W  = VALUE_WIDTH + 1;
	localparam int TERM_W  = VALUE_WIDTH + 2;
	// signed multiplier operand must also hold a zero-extended low limb
	localparam int MUL_A_W = (TERM_W > SPACING_W + 1) ? TERM_W : SPACING_W + 1;
	localparam int PROD_W  = MUL_A_W + SPACING_W;
	localparam int ACC_W   = PROD_W + SPACING_W + 2;

	localparam int GRAD_SHIFT = FRAC_BITS + 1;
	localparam int LAP_SHIFT  = 2 * FRAC_BITS;

	localparam logic [DIM_W-1:0]     DIM_RESET     = DIM_W'(1 << AXIS_BITS);
	localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(1 << FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_X = 3'd0,
		REG_DIM_Y = 3'd1,
		REG_DIM_Z = 3'd2,
		REG_INV_X = 3'd3,
		REG_INV_Y = 3'd4,
		REG_INV_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [1:0] {
		RD_CENTER,
		RD_LOWER,
		RD_UPPER
	} rd_sel_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_GRAD,
		MUL_TERM,
		MUL_U_LO,
		MUL_U_HI
	} mul_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_C,
		S_RD_LO,
		S_RD_HI,
		S_DIFF,
		S_MUL_G,
		S_MUL_T,
		S_MUL_ULO,
		S_MUL_UHI,
		S_ACC,
		S_FIN
	} state_t;

	typedef struct packed {
		logic    load;
		logic    mem_we;
		rd_sel_t rd_sel;
		logic    cap_center;
		logic    cap_lower;
		logic    diff_en;
		mul_op_t mul_op;
		logic    grad_we;
		logic    acc_lo;
		logic    acc_hi;
		logic    fin;
		logic    oor_out;
		axis_t   axis;
	} dp_cmd_t;

	typedef struct packed {
		logic oor;
	} dp_stat_t;

endpackage

`default_nettype wire

### sv/ggl_dp.sv
// Datapath: voxel memory, neighbour addressing, shared multiplier, accumulator and result registers.
`default_nettype none

module ggl_dp (
	input  wire                                   clk,
	input  wire  ggl_pkg::dp_cmd_t                cmd,
	output ggl_pkg::dp_stat_t                     stat,
	input  wire  [ggl_pkg::AXIS_BITS-1:0]         coord_x,
	input  wire  [ggl_pkg::AXIS_BITS-1:0]         coord_y,
	input  wire  [ggl_pkg::AXIS_BITS-1:0]         coord_z,
	input  wire  signed [ggl_pkg::VALUE_WIDTH-1:0] voxel_value,
	input  wire  [ggl_pkg::DIM_W-1:0]             dim_x,
	input  wire  [ggl_pkg::DIM_W-1:0]             dim_y,
	input  wire  [ggl_pkg::DIM_W-1:0]             dim_z,
	input  wire  [ggl_pkg::SPACING_W-1:0]         inv_x,
	input  wire  [ggl_pkg::SPACING_W-1:0]         inv_y,
	input  wire  [ggl_pkg::SPACING_W-1:0]         inv_z,
	output logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_x,
	output logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_y,
	output logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_z,
	output logic signed [ggl_pkg::VALUE_WIDTH-1:0] laplace_value,
	output logic                                  status
);

	localparam int AB  = ggl_pkg::AXIS_BITS;
	localparam int VW  = ggl_pkg::VALUE_WIDTH;
	localparam int DW  = ggl_pkg::DIM_W;
	localparam int SW  = ggl_pkg::SPACING_W;
	localparam int MW  = ggl_pkg::MUL_A_W;
	localparam int PW  = ggl_pkg::PROD_W;
	localparam int AW  = ggl_pkg::ACC_W;
	localparam int GSH = ggl_pkg::GRAD_SHIFT;
	localparam int LSH = ggl_pkg::LAP_SHIFT;

	localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

	logic [AB-1:0] px_q, py_q, pz_q;
	logic [DW-1:0] ex, ey, ez;
	logic [AB-1:0] p_sel, p_lo, p_hi, p_nb;
	logic [DW-1:0] e_sel;
	logic [SW-1:0] inv_sel;
	logic          has_lo, has_hi;
	logic [AB-1:0] ax, ay, az;
	logic [ggl_pkg::ADDR_W-1:0] addr;

	logic [VW-1:0]        mem [ggl_pkg::DEPTH];
	logic signed [VW-1:0] rd_q;
	logic signed [VW-1:0] center_q, lower_q;

	logic signed [ggl_pkg::DIFF_W-1:0] diff_q, fwd_q, bwd_q;
	logic signed [ggl_pkg::TERM_W-1:0] term_q;

	logic signed [MW-1:0]   mul_a;
	logic signed [SW:0]     mul_b;
	logic signed [MW+SW:0]  prod_full;
	logic signed [PW-1:0]   prod_q;
	logic signed [MW-1:0]   u_hi_q;
	logic signed [AW-1:0]   acc_q;

	logic signed [PW-1:0]     g_round;
	logic [PW-GSH-1:0]        g_sh;
	logic [VW-1:0]            g_sat;
	logic signed [AW-1:0]     l_round;
	logic [AW-LSH-1:0]        l_sh;
	logic [VW-1:0]            l_sat;

	// range check on the incoming coordinates; coordinates never exceed the store
	assign stat.oor = ({1'b0, coord_x} >= dim_x) || ({1'b0, coord_y} >= dim_y) ||
		({1'b0, coord_z} >= dim_z);

	assign ex = (dim_x > ggl_pkg::DIM_RESET) ? ggl_pkg::DIM_RESET : dim_x;
	assign ey = (dim_y > ggl_pkg::DIM_RESET) ? ggl_pkg::DIM_RESET : dim_y;
	assign ez = (dim_z > ggl_pkg::DIM_RESET) ? ggl_pkg::DIM_RESET : dim_z;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= coord_x;
			py_q <= coord_y;
			pz_q <= coord_z;
		end
	end

	always_comb begin
		case (cmd.axis)
			ggl_pkg::AXIS_X: begin
				p_sel   = px_q;
				e_sel   = ex;
				inv_sel = inv_x;
			end
			ggl_pkg::AXIS_Y: begin
				p_sel   = py_q;
				e_sel   = ey;
				inv_sel = inv_y;
			end
			default: begin
				p_sel   = pz_q;
				e_sel   = ez;
				inv_sel = inv_z;
			end
		endcase
	end

	// clamp neighbours to the grid edge
	assign has_lo = (p_sel != '0);
	assign has_hi = (({1'b0, p_sel} + DW'(1)) < e_sel);
	assign p_lo   = has_lo ? p_sel - AB'(1) : p_sel;
	assign p_hi   = has_hi ? p_sel + AB'(1) : p_sel;
	assign p_nb   = (cmd.rd_sel == ggl_pkg::RD_LOWER) ? p_lo : p_hi;

	always_comb begin
		ax = px_q;
		ay = py_q;
		az = pz_q;
		if (cmd.rd_sel != ggl_pkg::RD_CENTER) begin
			case (cmd.axis)
				ggl_pkg::AXIS_X: ax = p_nb;
				ggl_pkg::AXIS_Y: ay = p_nb;
				default:         az = p_nb;
			endcase
		end
	end

	assign addr = cmd.mem_we ? {coord_z, coord_y, coord_x} : {az, ay, ax};

	// single-port voxel store
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[addr] <= voxel_value;
		end else begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_center) begin
			center_q <= rd_q;
		end
		if (cmd.cap_lower) begin
			lower_q <= rd_q;
		end
		if (cmd.diff_en) begin
			diff_q <= ggl_pkg::DIFF_W'(rd_q) - ggl_pkg::DIFF_W'(lower_q);
			fwd_q  <= has_hi ? ggl_pkg::DIFF_W'(rd_q) - ggl_pkg::DIFF_W'(center_q) : '0;
			bwd_q  <= has_lo ? ggl_pkg::DIFF_W'(center_q) - ggl_pkg::DIFF_W'(lower_q) : '0;
		end
		if (cmd.mul_op == ggl_pkg::MUL_GRAD) begin
			term_q <= ggl_pkg::TERM_W'(fwd_q) - ggl_pkg::TERM_W'(bwd_q);
		end
	end

	// shared signed-by-unsigned multiplier, one product per cycle
	always_comb begin
		case (cmd.mul_op)
			ggl_pkg::MUL_GRAD: mul_a = MW'(diff_q);
			ggl_pkg::MUL_TERM: mul_a = MW'(term_q);
			ggl_pkg::MUL_U_LO: mul_a = $signed({{(MW-SW){1'b0}}, prod_q[SW-1:0]});
			ggl_pkg::MUL_U_HI: mul_a = u_hi_q;
			default:           mul_a = '0;
		endcase
	end

	assign mul_b     = $signed({1'b0, inv_sel});
	assign prod_full = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_op != ggl_pkg::MUL_NONE) begin
			prod_q <= prod_full[PW-1:0];
		end
		if (cmd.mul_op == ggl_pkg::MUL_U_LO) begin
			u_hi_q <= prod_q[PW-1:SW];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (cmd.acc_lo) begin
			acc_q <= acc_q + AW'(prod_q);
		end else if (cmd.acc_hi) begin
			acc_q <= acc_q + (AW'(prod_q) <<< SW);
		end
	end

	// round half up, drop fraction, saturate
	assign g_round = prod_q + (PW'(1) << (GSH - 1));
	assign g_sh    = g_round[PW-1:GSH];
	assign g_sat   = ((&g_sh[PW-GSH-1:VW-1]) || !(|g_sh[PW-GSH-1:VW-1])) ? g_sh[VW-1:0] :
		(g_sh[PW-GSH-1] ? VAL_MIN : VAL_MAX);

	assign l_round = acc_q + (AW'(1) << (LSH - 1));
	assign l_sh    = l_round[AW-1:LSH];
	assign l_sat   = ((&l_sh[AW-LSH-1:VW-1]) || !(|l_sh[AW-LSH-1:VW-1])) ? l_sh[VW-1:0] :
		(l_sh[AW-LSH-1] ? VAL_MIN : VAL_MAX);

	always_ff @(posedge clk) begin
		if (cmd.oor_out) begin
			grad_x        <= '0;
			grad_y        <= '0;
			grad_z        <= '0;
			laplace_value <= '0;
			status        <= 1'b1;
		end else begin
			if (cmd.grad_we) begin
				case (cmd.axis)
					ggl_pkg::AXIS_X: grad_x <= g_sat;
					ggl_pkg::AXIS_Y: grad_y <= g_sat;
					default:         grad_z <= g_sat;
				endcase
			end
			if (cmd.fin) begin
				laplace_value <= l_sat;
				status        <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### sv/ggl_ctrl.sv
// Controller: sequences voxel reads, multiplies and accumulation for one transaction.
`default_nettype none

module ggl_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire                     req_type,
	input  wire  ggl_pkg::dp_stat_t stat,
	output logic                    busy,
	output logic                    done,
	output ggl_pkg::dp_cmd_t        cmd
);

	ggl_pkg::state_t state_q, state_d;
	ggl_pkg::axis_t  axis_q, axis_d;
	logic            done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ggl_pkg::S_IDLE;
			axis_q  <= ggl_pkg::AXIS_X;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		axis_d     = axis_q;
		done_d     = 1'b0;
		cmd        = '0;
		cmd.rd_sel = ggl_pkg::RD_CENTER;
		cmd.mul_op = ggl_pkg::MUL_NONE;
		cmd.axis   = axis_q;
		unique case (state_q)
			ggl_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (req_type == ggl_pkg::REQ_WRITE) begin
						cmd.mem_we = 1'b1;
					end else if (stat.oor) begin
						cmd.oor_out = 1'b1;
						done_d      = 1'b1;
					end else begin
						state_d = ggl_pkg::S_RD_C;
						axis_d  = ggl_pkg::AXIS_X;
					end
				end
			end
			ggl_pkg::S_RD_C: begin
				state_d = ggl_pkg::S_RD_LO;
			end
			ggl_pkg::S_RD_LO: begin
				cmd.rd_sel     = ggl_pkg::RD_LOWER;
				// the centre is captured only on the first axis
				cmd.cap_center = (axis_q == ggl_pkg::AXIS_X);
				state_d        = ggl_pkg::S_RD_HI;
			end
			ggl_pkg::S_RD_HI: begin
				cmd.rd_sel    = ggl_pkg::RD_UPPER;
				cmd.cap_lower = 1'b1;
				state_d       = ggl_pkg::S_DIFF;
			end
			ggl_pkg::S_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = ggl_pkg::S_MUL_G;
			end
			ggl_pkg::S_MUL_G: begin
				cmd.mul_op = ggl_pkg::MUL_GRAD;
				state_d    = ggl_pkg::S_MUL_T;
			end
			ggl_pkg::S_MUL_T: begin
				cmd.mul_op  = ggl_pkg::MUL_TERM;
				cmd.grad_we = 1'b1;
				state_d     = ggl_pkg::S_MUL_ULO;
			end
			ggl_pkg::S_MUL_ULO: begin
				cmd.mul_op = ggl_pkg::MUL_U_LO;
				state_d    = ggl_pkg::S_MUL_UHI;
			end
			ggl_pkg::S_MUL_UHI: begin
				cmd.mul_op = ggl_pkg::MUL_U_HI;
				cmd.acc_lo = 1'b1;
				state_d    = ggl_pkg::S_ACC;
			end
			ggl_pkg::S_ACC: begin
				cmd.acc_hi = 1'b1;
				unique case (axis_q)
					ggl_pkg::AXIS_X: begin
						axis_d  = ggl_pkg::AXIS_Y;
						state_d = ggl_pkg::S_RD_LO;
					end
					ggl_pkg::AXIS_Y: begin
						axis_d  = ggl_pkg::AXIS_Z;
						state_d = ggl_pkg::S_RD_LO;
					end
					default: begin
						state_d = ggl_pkg::S_FIN;
					end
				endcase
			end
			ggl_pkg::S_FIN: begin
				cmd.fin = 1'b1;
				done_d  = 1'b1;
				state_d = ggl_pkg::S_IDLE;
			end
			default: begin
				state_d = ggl_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ggl_pkg::S_IDLE);
	assign done = done_q;

`ifndef SYNTH
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ggl_pkg::S_FIN || $past(state_q) == ggl_pkg::S_IDLE))
		else $error("result strobe without a finishing state");

	a_last_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ggl_pkg::S_ACC && axis_q == ggl_pkg::AXIS_Z) |=> state_q == ggl_pkg::S_FIN)
		else $error("last axis did not finish the query");

	a_fin_axis: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ggl_pkg::S_FIN |-> axis_q == ggl_pkg::AXIS_Z)
		else $error("query finished before all axes were summed");

	a_grad_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grad_we |-> $past(cmd.mul_op) == ggl_pkg::MUL_GRAD)
		else $error("gradient written without its product");
`endif

endmodule

`default_nettype wire

### sv/grid_gradient_laplacian_stencil_core.sv
// Top level: configuration registers and controller/datapath instances.
//
// channel   direction  handshake               payload
// command   in         start & !busy           req_type, coord_x/y/z, voxel_value
// result    out        done (one cycle)        grad_x/y/z, laplace_value, status
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// A voxel write completes as it is accepted; an out-of-range query gives its result the next cycle.
// An in-range query makes seven reads of the single-port voxel memory and four passes per axis
// through the one shared multiplier before the done strobe. A new command is taken in the cycle
// done is shown. The done strobe is high for exactly one cycle and cannot be stalled. Reset
// clears control state and configuration only; the voxel store has no reset.
`default_nettype none

module grid_gradient_laplacian_stencil_core (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire                                   req_type,
	input  wire  [ggl_pkg::AXIS_BITS-1:0]         coord_x,
	input  wire  [ggl_pkg::AXIS_BITS-1:0]         coord_y,
	input  wire  [ggl_pkg::AXIS_BITS-1:0]         coord_z,
	input  wire  signed [ggl_pkg::VALUE_WIDTH-1:0] voxel_value,
	output logic                                  done,
	output logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_x,
	output logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_y,
	output logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_z,
	output logic signed [ggl_pkg::VALUE_WIDTH-1:0] laplace_value,
	output logic                                  status,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [ggl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [ggl_pkg::SPACING_W-1:0]         cfg_data
);

	logic [ggl_pkg::DIM_W-1:0]     dim_x_q, dim_y_q, dim_z_q;
	logic [ggl_pkg::SPACING_W-1:0] inv_x_q, inv_y_q, inv_z_q;

	ggl_pkg::dp_cmd_t  cmd;
	ggl_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	// unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= ggl_pkg::DIM_RESET;
			dim_y_q <= ggl_pkg::DIM_RESET;
			dim_z_q <= ggl_pkg::DIM_RESET;
			inv_x_q <= ggl_pkg::SPACING_RESET;
			inv_y_q <= ggl_pkg::SPACING_RESET;
			inv_z_q <= ggl_pkg::SPACING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ggl_pkg::REG_DIM_X: dim_x_q <= cfg_data[ggl_pkg::DIM_W-1:0];
				ggl_pkg::REG_DIM_Y: dim_y_q <= cfg_data[ggl_pkg::DIM_W-1:0];
				ggl_pkg::REG_DIM_Z: dim_z_q <= cfg_data[ggl_pkg::DIM_W-1:0];
				ggl_pkg::REG_INV_X: inv_x_q <= cfg_data;
				ggl_pkg::REG_INV_Y: inv_y_q <= cfg_data;
				ggl_pkg::REG_INV_Z: inv_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ggl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.busy     (busy),
		.done     (done),
		.cmd      (cmd)
	);

	ggl_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.stat          (stat),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.coord_z       (coord_z),
		.voxel_value   (voxel_value),
		.dim_x         (dim_x_q),
		.dim_y         (dim_y_q),
		.dim_z         (dim_z_q),
		.inv_x         (inv_x_q),
		.inv_y         (inv_y_q),
		.inv_z         (inv_z_q),
		.grad_x        (grad_x),
		.grad_y        (grad_y),
		.grad_z        (grad_z),
		.laplace_value (laplace_value),
		.status        (status)
	);

endmodule

`default_nettype wire

### verif/grid_stencil_checker.sv
// Stencil checker: mirrors the configuration and voxel store, predicts each query and compares results.
module grid_stencil_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic                                   req_type,
	input  logic [ggl_pkg::AXIS_BITS-1:0]          coord_x,
	input  logic [ggl_pkg::AXIS_BITS-1:0]          coord_y,
	input  logic [ggl_pkg::AXIS_BITS-1:0]          coord_z,
	input  logic signed [ggl_pkg::VALUE_WIDTH-1:0] voxel_value,
	input  logic                                   done,
	input  logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_x,
	input  logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_y,
	input  logic signed [ggl_pkg::VALUE_WIDTH-1:0] grad_z,
	input  logic signed [ggl_pkg::VALUE_WIDTH-1:0] laplace_value,
	input  logic                                   status,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [ggl_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ggl_pkg::SPACING_W-1:0]          cfg_data,
	output int                                     open_count,
	output int                                     fail_count
);
	import ggl_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [ADDR_W-1:0]             at;
		logic signed [VALUE_WIDTH-1:0] gx;
		logic signed [VALUE_WIDTH-1:0] gy;
		logic signed [VALUE_WIDTH-1:0] gz;
		logic signed [VALUE_WIDTH-1:0] lap;
		logic                          st;
	} stencil_t;

	localparam wide_t TOP_VAL = (wide_t'(1) <<< (VALUE_WIDTH - 1)) - wide_t'(1);
	localparam wide_t BOT_VAL = -(wide_t'(1) <<< (VALUE_WIDTH - 1));

	logic [VALUE_WIDTH-1:0] mirror [DEPTH];
	logic [DIM_W-1:0]       grid_dim [3];
	logic [SPACING_W-1:0]   inv_step [3];
	stencil_t               due_stencils [$];
	int                     misses;

	// dims beyond the store behave as the full store
	function automatic int span(input logic [DIM_W-1:0] d);
		return (d > DIM_RESET) ? int'(DIM_RESET) : int'(d);
	endfunction

	function automatic wide_t stored(input int x, input int y, input int z);
		return $signed(mirror[(z << (2 * AXIS_BITS)) | (y << AXIS_BITS) | x]);
	endfunction

	function automatic logic signed [VALUE_WIDTH-1:0] clip(input wide_t v);
		if (v > TOP_VAL)
			return TOP_VAL[VALUE_WIDTH-1:0];
		if (v < BOT_VAL)
			return BOT_VAL[VALUE_WIDTH-1:0];
		return v[VALUE_WIDTH-1:0];
	endfunction

	function automatic stencil_t stencil_at(input logic [AXIS_BITS-1:0] px,
			input logic [AXIS_BITS-1:0] py, input logic [AXIS_BITS-1:0] pz);
		stencil_t                      r;
		int                            p [3];
		int                            lo [3];
		int                            hi [3];
		int                            d;
		wide_t                         c, vl, vh, inv, fwd, bwd, lap, g;
		logic signed [VALUE_WIDTH-1:0] slope [3];
		r = '0;
		r.at = {pz, py, px};
		p[AXIS_X] = px;
		p[AXIS_Y] = py;
		p[AXIS_Z] = pz;
		for (int a = 0; a < 3; a++)
			if (p[a] >= span(grid_dim[a]))
				r.st = 1'b1;
		if (r.st)
			return r;
		c = stored(p[0], p[1], p[2]);
		lap = '0;
		for (int a = 0; a < 3; a++) begin
			d = span(grid_dim[a]);
			lo = p;
			hi = p;
			if (p[a] > 0)
				lo[a] = p[a] - 1;
			if (p[a] + 1 < d)
				hi[a] = p[a] + 1;
			vl = stored(lo[0], lo[1], lo[2]);
			vh = stored(hi[0], hi[1], hi[2]);
			inv = {96'd0, inv_step[a]};
			// halve and return to Q16.16 in one rounded shift
			g = ((vh - vl) * inv + (wide_t'(1) <<< (GRAD_SHIFT - 1))) >>> GRAD_SHIFT;
			slope[a] = clip(g);
			// a missing neighbour contributes no difference
			fwd = (p[a] + 1 < d) ? vh - c : wide_t'(0);
			bwd = (p[a] > 0) ? c - vl : wide_t'(0);
			lap = lap + (fwd - bwd) * inv * inv;
		end
		r.gx = slope[AXIS_X];
		r.gy = slope[AXIS_Y];
		r.gz = slope[AXIS_Z];
		r.lap = clip((lap + (wide_t'(1) <<< (LAP_SHIFT - 1))) >>> LAP_SHIFT);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stencil_t want;
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				grid_dim[a] = DIM_RESET;
				inv_step[a] = SPACING_RESET;
			end
			due_stencils.delete();
			misses = 0;
			open_count <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DIM_X: grid_dim[AXIS_X] = cfg_data[DIM_W-1:0];
					REG_DIM_Y: grid_dim[AXIS_Y] = cfg_data[DIM_W-1:0];
					REG_DIM_Z: grid_dim[AXIS_Z] = cfg_data[DIM_W-1:0];
					REG_INV_X: inv_step[AXIS_X] = cfg_data;
					REG_INV_Y: inv_step[AXIS_Y] = cfg_data;
					REG_INV_Z: inv_step[AXIS_Z] = cfg_data;
					default: ;
				endcase
			end
			// retire the finished result before taking the next transaction
			if (done) begin
				if (due_stencils.size() == 0) begin
					misses++;
					if (misses <= 10)
						$display("result with nothing outstanding: %h %h %h %h %b",
							grad_x, grad_y, grad_z, laplace_value, status);
				end else begin
					want = due_stencils.pop_front();
					if (grad_x !== want.gx || grad_y !== want.gy || grad_z !== want.gz ||
							laplace_value !== want.lap || status !== want.st) begin
						misses++;
						if (misses <= 10)
							$display("mismatch %h want/got gx %h/%h gy %h/%h gz %h/%h lap %h/%h st %b/%b",
								want.at, want.gx, grad_x, want.gy, grad_y, want.gz, grad_z,
								want.lap, laplace_value, want.st, status);
					end
				end
			end
			if (start && !busy) begin
				if (req_type == REQ_WRITE)
					mirror[{coord_z, coord_y, coord_x}] = voxel_value;
				else
					due_stencils.push_back(stencil_at(coord_x, coord_y, coord_z));
			end
			open_count <= due_stencils.size();
			fail_count <= misses;
		end
	end

endmodule

### verif/grid_gradient_laplacian_stencil_core_test.sv
// Testbench top: drives voxel writes, stencil queries and register writes, and gives the verdict.
module grid_gradient_laplacian_stencil_core_test;
	import ggl_pkg::*;

	localparam logic [CFG_IDX_W-1:0]   REG_SPARE_A   = 3'd6;
	localparam logic [CFG_IDX_W-1:0]   REG_SPARE_B   = 3'd7;
	localparam logic [VALUE_WIDTH-1:0] VAL_MAX       = 32'h7FFF_FFFF;
	localparam logic [VALUE_WIDTH-1:0] VAL_MIN       = 32'h8000_0000;
	localparam int                     SETTLE_CYCLES = 32;
	localparam int                     PHASES        = 14;
	localparam int                     CALM_PHASES   = 3;
	localparam int                     PHASE_ITEMS   = 132;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          start       = 1'b0;
	logic                          req_type    = REQ_WRITE;
	logic [AXIS_BITS-1:0]          coord_x     = '0;
	logic [AXIS_BITS-1:0]          coord_y     = '0;
	logic [AXIS_BITS-1:0]          coord_z     = '0;
	logic signed [VALUE_WIDTH-1:0] voxel_value = '0;
	logic                          cfg_valid   = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index   = '0;
	logic [SPACING_W-1:0]          cfg_data    = '0;
	logic                          busy, done, status, cfg_ready;
	logic signed [VALUE_WIDTH-1:0] grad_x, grad_y, grad_z, laplace_value;
	int                            open_count, fail_count;

	logic [DIM_W-1:0] grid_dim [3];
	bit               filled [DEPTH];
	int               sent;
	int               gap_pct;

	grid_gradient_laplacian_stencil_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .voxel_value(voxel_value),
		.done(done), .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
		.laplace_value(laplace_value), .status(status), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	grid_stencil_checker i_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .voxel_value(voxel_value),
		.done(done), .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
		.laplace_value(laplace_value), .status(status), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.open_count(open_count), .fail_count(fail_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int span(input logic [DIM_W-1:0] d);
		return (d > DIM_RESET) ? int'(DIM_RESET) : int'(d);
	endfunction

	function automatic logic [ADDR_W-1:0] at3(input int x, input int y, input int z);
		return ADDR_W'((z << (2 * AXIS_BITS)) | (y << AXIS_BITS) | x);
	endfunction

	// neighbour on one axis, clamped to the grid edge the way the core reads it
	function automatic logic [ADDR_W-1:0] nb_at(input int p [3], input int a, input int step);
		int q [3];
		q = p;
		if (step < 0 && p[a] > 0)
			q[a] = p[a] - 1;
		if (step > 0 && p[a] + 1 < span(grid_dim[a]))
			q[a] = p[a] + 1;
		return at3(q[0], q[1], q[2]);
	endfunction

	// true when a query here reads only written voxels
	function automatic bit ready_at(input int p [3]);
		bit ok;
		for (int a = 0; a < 3; a++)
			if (p[a] >= span(grid_dim[a]))
				return 1'b1;
		ok = 1'b1;
		for (int a = 0; a < 3; a++)
			for (int s = -1; s <= 1; s++)
				ok &= filled[nb_at(p, a, s)];
		return ok;
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		logic [VALUE_WIDTH-1:0] v;
		case ($urandom_range(0, 7))
			0: v = VAL_MAX;
			1: v = VAL_MIN;
			2: v = '0;
			3, 4: v = $urandom_range(0, 1 << 18) - (1 << 17);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [SPACING_W-1:0] pick_step();
		logic [SPACING_W-1:0] s;
		case ($urandom_range(0, 7))
			0: s = 1;
			1: s = '1;
			2: s = SPACING_RESET;
			3: s = $urandom_range(0, 16);
			4, 5: s = $urandom_range(1 << 12, 1 << 18);
			default: s = $urandom;
		endcase
		return s;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		logic [DIM_W-1:0] d;
		case ($urandom_range(0, 9))
			0: d = 1;
			1: d = DIM_RESET;
			2: d = $urandom_range(33, 63);
			default: d = $urandom_range(2, 6);
		endcase
		return d;
	endfunction

	task automatic issue(input logic kind, input logic [ADDR_W-1:0] at,
			input logic [VALUE_WIDTH-1:0] v);
		if ($urandom_range(1, 100) <= gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		{coord_z, coord_y, coord_x} <= at;
		voxel_value <= v;
		do @(posedge clk); while (busy);
		if (kind == REQ_WRITE)
			filled[at] = 1'b1;
		sent++;
	endtask

	task automatic ask(input int p [3]);
		issue(REQ_QUERY, at3(p[0], p[1], p[2]), $urandom);
	endtask

	// fill the stencil around a point, refresh some of it, then query the point
	task automatic patch(input int p [3]);
		logic [ADDR_W-1:0] at;
		for (int a = 0; a < 3; a++)
			for (int s = -1; s <= 1; s++) begin
				at = nb_at(p, a, s);
				if (!filled[at] || $urandom_range(0, 3) == 0)
					issue(REQ_WRITE, at, pick_value());
			end
		ask(p);
	endtask

	// hold off until every result is in and the core has gone quiet
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (open_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [SPACING_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_grid(input logic [DIM_W-1:0] dx, input logic [DIM_W-1:0] dy,
			input logic [DIM_W-1:0] dz, input logic [SPACING_W-1:0] sx,
			input logic [SPACING_W-1:0] sy, input logic [SPACING_W-1:0] sz);
		logic [SPACING_W-1:0] junk;
		drain();
		// upper data bits are dropped by the dim registers
		junk = $urandom_range(0, 1) ? $urandom : '0;
		grid_dim[AXIS_X] = dx;
		grid_dim[AXIS_Y] = dy;
		grid_dim[AXIS_Z] = dz;
		cfg_put(REG_DIM_X, {junk[SPACING_W-1:DIM_W], dx});
		cfg_put(REG_DIM_Y, {junk[SPACING_W-1:DIM_W], dy});
		cfg_put(REG_DIM_Z, {junk[SPACING_W-1:DIM_W], dz});
		cfg_put(REG_INV_X, sx);
		cfg_put(REG_INV_Y, sy);
		cfg_put(REG_INV_Z, sz);
		cfg_put($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int quota);
		int p [3];
		bit boxed;
		int stop;
		int pick;
		stop = sent + quota;
		boxed = span(grid_dim[AXIS_X]) > 0 && span(grid_dim[AXIS_Y]) > 0 &&
			span(grid_dim[AXIS_Z]) > 0;
		while (sent < stop) begin
			pick = $urandom_range(0, 9);
			for (int a = 0; a < 3; a++)
				p[a] = (boxed && pick < 7) ? $urandom_range(0, span(grid_dim[a]) - 1) :
					$urandom_range(0, (1 << AXIS_BITS) - 1);
			if (pick < 7) begin
				if (boxed && (pick < 4 || !ready_at(p)))
					patch(p);
				else
					ask(p);
			end else if (pick < 9) begin
				// anywhere, out of range included; write instead where a read would be unsafe
				if (ready_at(p))
					ask(p);
				else
					issue(REQ_WRITE, at3(p[0], p[1], p[2]), pick_value());
			end else begin
				issue(REQ_WRITE, at3(p[0], p[1], p[2]), pick_value());
			end
		end
	endtask

	initial begin
		int p [3];
		for (int a = 0; a < 3; a++)
			grid_dim[a] = DIM_RESET;
		sent = 0;
		gap_pct = 20;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner at the origin: one-sided differences on every axis
		issue(REQ_WRITE, at3(0, 0, 0), VAL_MAX);
		issue(REQ_WRITE, at3(1, 0, 0), VAL_MIN);
		issue(REQ_WRITE, at3(0, 1, 0), '0);
		issue(REQ_WRITE, at3(0, 0, 1), 32'h0001_0000);
		p = '{0, 0, 0};
		ask(p);
		// far corner, upper neighbours clamp onto the centre
		issue(REQ_WRITE, at3(31, 31, 31), VAL_MIN);
		issue(REQ_WRITE, at3(30, 31, 31), VAL_MAX);
		issue(REQ_WRITE, at3(31, 30, 31), 32'hFFFF_8000);
		issue(REQ_WRITE, at3(31, 31, 30), 32'h0000_0001);
		p = '{31, 31, 31};
		ask(p);

		// single-voxel axes at the largest spacing, then out of range on each axis
		set_grid(1, 1, 1, '1, '1, '1);
		p = '{0, 0, 0};
		ask(p);
		p = '{31, 0, 0};
		ask(p);
		p = '{0, 31, 0};
		ask(p);
		p = '{0, 0, 31};
		ask(p);

		// dims beyond the store act as full size; smallest and zero spacing
		set_grid(63, 40, 33, '1, 1, 0);
		p = '{31, 31, 31};
		ask(p);
		p = '{0, 0, 0};
		ask(p);

		// empty grid: every query is out of range, writes still land
		set_grid(0, 5, 5, SPACING_RESET, SPACING_RESET, SPACING_RESET);
		ask(p);
		issue(REQ_WRITE, at3(17, 3, 9), pick_value());

		for (int k = 0; k < PHASES; k++) begin
			set_grid(pick_dim(), pick_dim(), pick_dim(), pick_step(), pick_step(), pick_step());
			if (k >= PHASES - CALM_PHASES || $urandom_range(0, 3) == 0)
				gap_pct = 0;
			else
				gap_pct = $urandom_range(5, 40);
			run_phase(PHASE_ITEMS);
		end

		drain();
		if (fail_count == 0 && open_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
